### rtl/mbrs_pkg.sv
// Package with types, constants and the CRC helper for the Modbus RTU slave.
package mbrs_pkg;
    localparam int NumRegs = 33;
    localparam int RxBytes = 128;
    localparam int MaxRead = 29;
    localparam int CntW = $clog2(RxBytes + 1);
    localparam int AdrW = $clog2(RxBytes);
    localparam int RegW = $clog2(NumRegs);

    localparam logic [7:0] FcRead = 8'h03;
    localparam logic [7:0] FcWrite = 8'h10;
    localparam logic [7:0] ExcFlag = 8'h80;
    localparam logic [7:0] ExcFunc = 8'd1;
    localparam logic [7:0] ExcRange = 8'd2;
    localparam logic [7:0] ExcCount = 8'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_out;

    // Closed frame handed from the front part to the back part.
    typedef struct packed {
        logic [CntW-1:0] len;
        logic            bad;
    } t_job;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        x = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction
endpackage

### rtl/mbrs_front.sv
// Front part: collects frame bytes into the frame store and queues closed frames.
module mbrs_front import mbrs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_in             i_data,
    output logic            o_wr_en,
    output logic [AdrW-1:0] o_wr_addr,
    output logic [7:0]      o_wr_data,
    output logic            o_job_valid,
    input  logic            i_job_stall,
    output t_job            o_job
);
    logic [CntW-1:0] r_count, n_count;
    logic            r_ov, n_ov;
    logic            r_jv, n_jv;
    t_job            r_job, n_job;
    logic            acc;

    // The frame store is shared, so no new word is taken while the back part works.
    assign o_stall = r_jv || i_job_stall;
    assign acc = i_valid && !o_stall;
    assign o_wr_en = acc && (r_count < CntW'(RxBytes));
    assign o_wr_addr = r_count[AdrW-1:0];
    assign o_wr_data = i_data.rx_byte;
    assign o_job_valid = r_jv;
    assign o_job = r_job;

    always_comb begin
        n_count = r_count;
        n_ov = r_ov;
        n_jv = r_jv && i_job_stall;
        n_job = r_job;
        if (acc) begin
            if (o_wr_en) begin
                n_count = r_count + CntW'(1);
            end else begin
                n_ov = 1'b1;
            end
            if (i_data.frame_end) begin
                n_jv = 1'b1;
                n_job.len = o_wr_en ? r_count + CntW'(1) : r_count;
                n_job.bad = r_ov || !o_wr_en;
                n_count = '0;
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ov <= 1'b0;
            r_jv <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ov <= n_ov;
            r_jv <= n_jv;
        end
        r_job <= n_job;
    end
endmodule

### rtl/mbrs_back.sv
// Back part: checks a closed frame, runs it on the register table, replies unless addr 0.
module mbrs_back import mbrs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [AdrW-1:0] i_wr_addr,
    input  logic [7:0]      i_wr_data,
    input  logic            i_job_valid,
    output logic            o_job_stall,
    input  t_job            i_job,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out            o_data
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_HDR  = 8'b00000010,
        S_CRC  = 8'b00000100,
        S_DEC  = 8'b00001000,
        S_WR   = 8'b00010000,
        S_RDAT = 8'b00100000,
        S_EMIT = 8'b01000000,
        S_DONE = 8'b10000000
    } t_state;

    logic [7:0]  r_mem [RxBytes];
    logic [7:0]  r_rd;
    logic [AdrW-1:0] rd_addr;
    logic [15:0] r_tab [NumRegs];
    logic [NumRegs-1:0] r_tvalid;

    t_state      r_st;
    logic [CntW-1:0] r_idx;
    logic        r_rdv;
    t_job        r_job;
    logic [7:0]  r_hdr [7];
    logic [15:0] r_crc;
    logic [7:0]  r_clo, r_code;
    logic [15:0] r_whi;
    logic [7:0]  r_ocnt;
    logic [7:0]  r_olen;
    logic [15:0] r_ocrc;
    logic        r_ov;
    t_out        r_out;
    logic [15:0] r_rv;

    logic [15:0] start, qty;
    logic [16:0] endr;
    logic [7:0]  ebyte;
    logic [15:0] tab_rd;
    logic        out_free;

    assign o_job_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_data = r_out;
    assign start = {r_hdr[2], r_hdr[3]};
    assign qty = {r_hdr[4], r_hdr[5]};
    assign endr = {1'b0, start} + {1'b0, qty};
    assign rd_addr = r_idx[AdrW-1:0];
    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    function automatic logic [7:0] wbyte(input logic [15:0] v, input logic lo);
        return lo ? v[7:0] : v[15:8];
    endfunction

    // Reply byte at position r_ocnt: header, data or exception fields.
    always_comb begin
        tab_rd = r_rv;
        if (r_code != 8'd0) begin
            unique case (r_ocnt)
                8'd0: ebyte = r_hdr[0];
                8'd1: ebyte = r_hdr[1] | ExcFlag;
                default: ebyte = r_code;
            endcase
        end else if (r_hdr[1] == FcWrite) begin
            ebyte = (r_ocnt < 8'd6) ? r_hdr[r_ocnt[2:0]] : 8'd0;
        end else begin
            priority if (r_ocnt == 8'd0) ebyte = r_hdr[0];
            else if (r_ocnt == 8'd1) ebyte = r_hdr[1];
            else if (r_ocnt == 8'd2) ebyte = {qty[6:0], 1'b0};
            else ebyte = wbyte(tab_rd, r_ocnt[0] == 1'b0);
        end
    end

    logic [RegW:0] tidx;
    logic [8:0] dpos;
    assign dpos = {1'b0, r_ocnt} - 9'd3;
    assign tidx = (RegW+1)'(start + 16'(dpos[8:1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_tvalid <= '0;
        end else begin
            if ((r_st == S_EMIT || r_st == S_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_rdv <= 1'b0;
                        r_crc <= 16'hFFFF;
                        r_code <= 8'd0;
                        for (int k = 0; k < 7; k++) r_hdr[k] <= 8'd0;
                        r_st <= S_HDR;
                    end
                end
                S_HDR: begin
                    // One byte a cycle through the store; the read data comes in the cycle after its address.
                    r_rdv <= (r_idx < r_job.len);
                    if (r_idx < r_job.len) r_idx <= r_idx + CntW'(1);
                    if (r_rdv) begin
                        if (r_idx - CntW'(1) < CntW'(7)) begin
                            r_hdr[3'(r_idx - CntW'(1))] <= r_rd;
                        end
                        if (r_idx + CntW'(1) < r_job.len) begin
                            r_crc <= crc_byte(r_crc, r_rd);
                        end else if (r_idx < r_job.len) begin
                            r_clo <= r_rd;
                        end else begin
                            r_whi <= {r_rd, r_clo};
                        end
                    end
                    if (!r_rdv && r_idx != '0 && !(r_idx < r_job.len)) begin
                        r_st <= S_CRC;
                    end
                end
                S_CRC: begin
                    if (r_job.bad ||
                        9'(r_job.len) != ((r_hdr[1] == FcWrite) ?
                            ({1'b0, r_hdr[6]} + 9'd9) : 9'd8) ||
                        r_whi != r_crc) begin
                        r_code <= ExcFunc;
                    end else if (r_hdr[1] == FcRead) begin
                        if (qty == 16'd0 || qty > 16'(MaxRead)) r_code <= ExcCount;
                        else if (endr > 17'(NumRegs)) r_code <= ExcRange;
                    end else if (r_hdr[1] == FcWrite) begin
                        if (qty == 16'd0 || qty > 16'(NumRegs) ||
                            {8'd0, r_hdr[6]} != {qty[14:0], 1'b0}) r_code <= ExcCount;
                        else if (endr > 17'(NumRegs)) r_code <= ExcRange;
                    end else begin
                        r_code <= ExcFunc;
                    end
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    r_idx <= CntW'(7);
                    r_rdv <= 1'b0;
                    r_ocnt <= 8'd0;
                    r_ocrc <= 16'hFFFF;
                    if (r_code != 8'd0) r_olen <= 8'd3;
                    else if (r_hdr[1] == FcWrite) r_olen <= 8'd6;
                    else r_olen <= 8'(3 + 2 * qty);
                    if (r_code == 8'd0 && r_hdr[1] == FcWrite) r_st <= S_WR;
                    else r_st <= (r_hdr[0] == 8'd0) ? S_IDLE : S_RDAT;
                end
                S_WR: begin
                    // Data bytes streamed out of the store, one per cycle.
                    r_rdv <= (r_idx < r_job.len - CntW'(2));
                    if (r_idx < r_job.len - CntW'(2)) r_idx <= r_idx + CntW'(1);
                    if (r_rdv) begin
                        if (r_idx[0] == 1'b0) begin
                            r_clo <= r_rd;
                        end else begin
                            r_tab[RegW'(start + 16'((r_idx - CntW'(9)) >> 1))]
                                <= {r_clo, r_rd};
                            r_tvalid[RegW'(start + 16'((r_idx - CntW'(9)) >> 1))] <= 1'b1;
                        end
                    end
                    if (!r_rdv && !(r_idx < r_job.len - CntW'(2))) begin
                        r_st <= (r_hdr[0] == 8'd0) ? S_IDLE : S_RDAT;
                    end
                end
                S_RDAT: begin
                    if (r_ocnt >= 8'd3 && r_code == 8'd0 && r_hdr[1] == FcRead
                        && r_tvalid[tidx[RegW-1:0]]) begin
                        r_rv <= r_tab[tidx[RegW-1:0]];
                    end else begin
                        r_rv <= 16'd0;
                    end
                    r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.tx_byte <= ebyte;
                        r_out.tx_last <= 1'b0;
                        r_ocrc <= crc_byte(r_ocrc, ebyte);
                        r_ocnt <= r_ocnt + 8'd1;
                        r_st <= (r_ocnt + 8'd1 == r_olen) ? S_DONE : S_RDAT;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.tx_byte <= (r_ocnt == r_olen) ? r_ocrc[7:0] : r_ocrc[15:8];
                        r_out.tx_last <= (r_ocnt != r_olen);
                        r_ocnt <= r_ocnt + 8'd1;
                        if (r_ocnt != r_olen) r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/modbus_rtu_register_slave.sv
// Top level of the Modbus RTU holding-register slave.
// Bytes are taken one per cycle; input stalls from frame end until any reply is issued.
// After frame end the back part reads the frame once to check it and again to store a write.
// Each reply byte takes S_RDAT then S_EMIT, the two CRC bytes leave one per cycle, and the
// reply waits while the output stalls.
// Synchronous active-low reset empties the frame and clears the register table at once.
module modbus_rtu_register_slave import mbrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic            wr_en;
    logic [AdrW-1:0] wr_addr;
    logic [7:0]      wr_data;
    logic            job_valid, job_stall;
    t_job            job;

    mbrs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_job_valid(job_valid), .i_job_stall(job_stall), .o_job(job)
    );

    mbrs_back u_back (
        .i_clk, .i_rst_n,
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_job_valid(job_valid), .o_job_stall(job_stall), .i_job(job),
        .o_valid, .i_stall, .o_data
    );
endmodule
